[hdl/lsc_pkg.sv]
package lsc_pkg;

    // Default coordinate width
    localparam int CoordWidth = 16;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_X_LEFT   = 2'd0,
        CFG_X_RIGHT  = 2'd1,
        CFG_Y_BOTTOM = 2'd2,
        CFG_Y_TOP    = 2'd3
    } lsc_cfg_idx_t;

    // Window edges, in order of priority (the first listed wins)
    typedef enum logic [1:0] {
        EDGE_LEFT   = 2'd0,
        EDGE_RIGHT  = 2'd1,
        EDGE_TOP    = 2'd2,
        EDGE_BOTTOM = 2'd3
    } lsc_edge_t;

    // Lanes: the edges of endpoint a in edge order, then those of endpoint b
    localparam int NumLanes = 8;

    // Per-item control that rides alongside the coordinates
    typedef struct packed {
        logic [NumLanes-1:0] tries;  // edge intersection is a candidate
        logic [3:0]          c2;     // outcode of endpoint b
        logic [3:0]          c1;     // outcode of endpoint a
    } lsc_ctl_t;

endpackage

[hdl/lsc_front.sv]
module lsc_front
    import lsc_pkg::*;
#(
    parameter int W = CoordWidth
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            adv,
    input  logic                            in_valid,
    input  logic [W-1:0]                    ax,
    input  logic [W-1:0]                    ay,
    input  logic [W-1:0]                    bx,
    input  logic [W-1:0]                    by,
    input  logic [W-1:0]                    win_l,
    input  logic [W-1:0]                    win_r,
    input  logic [W-1:0]                    win_b,
    input  logic [W-1:0]                    win_t,
    output logic                            out_valid,
    output logic [NumLanes-1:0][2*W+1:0]    num,
    output logic [NumLanes-1:0][W:0]        den,
    output logic [NumLanes-1:0]             neg,
    output lsc_ctl_t                        ctl,
    output logic [4*W-1:0]                  coords
);

    localparam int DW = W + 1;
    localparam int PW = 2 * DW;

    // Stage 1 registers: magnitudes, signs, control
    logic                            s1_valid_reg;
    logic [NumLanes-1:0][DW-1:0]     m1_reg, m1_next;
    logic [NumLanes-1:0][DW-1:0]     m2_reg, m2_next;
    logic [NumLanes-1:0][DW-1:0]     md_reg, md_next;
    logic [NumLanes-1:0]             neg1_reg, neg1_next;
    lsc_ctl_t                        ctl1_reg, ctl1_next;
    logic [4*W-1:0]                  crd1_reg;

    // Stage 2 registers: products
    logic                            s2_valid_reg;
    logic [NumLanes-1:0][PW-1:0]     prod_reg;
    logic [NumLanes-1:0][DW-1:0]     md2_reg;
    logic [NumLanes-1:0]             neg2_reg;
    lsc_ctl_t                        ctl2_reg;
    logic [4*W-1:0]                  crd2_reg;

    // Set up the eight lanes: factors, divisor, sign and try flag
    always_comb begin
        logic signed [DW-1:0] sax, say, sbx, sby, sl, sr, sb, st;
        logic signed [DW-1:0] dx, dy, qx, qy, f1, f2, dv;
        logic                 dxnz, dynz, tr;
        sax = {ax[W-1], ax};
        say = {ay[W-1], ay};
        sbx = {bx[W-1], bx};
        sby = {by[W-1], by};
        sl  = {win_l[W-1], win_l};
        sr  = {win_r[W-1], win_r};
        sb  = {win_b[W-1], win_b};
        st  = {win_t[W-1], win_t};
        dx  = sbx - sax;
        dy  = sby - say;
        dxnz = (dx != '0);
        dynz = (dy != '0);
        ctl1_next.c1 = {say > st, say < sb, sax > sr, sax < sl};
        ctl1_next.c2 = {sby > st, sby < sb, sbx > sr, sbx < sl};
        for (int e = 0; e < NumLanes; e++) begin
            qx = (e >= 4) ? sbx : sax;
            qy = (e >= 4) ? sby : say;
            case (lsc_edge_t'(e[1:0]))
                EDGE_LEFT: begin
                    f1 = dy; f2 = sl - qx; dv = dx; tr = dxnz && (qx <= sl);
                end
                EDGE_RIGHT: begin
                    f1 = dy; f2 = sr - qx; dv = dx; tr = dxnz && (qx >= sr);
                end
                EDGE_TOP: begin
                    f1 = dx; f2 = st - qy; dv = dy; tr = dynz && (qy >= st);
                end
                EDGE_BOTTOM: begin
                    f1 = dx; f2 = sb - qy; dv = dy; tr = dynz && (qy <= sb);
                end
                default: begin
                    f1 = '0; f2 = '0; dv = '0; tr = 1'b0;
                end
            endcase
            m1_next[e]  = f1[DW-1] ? DW'(-f1) : DW'(f1);
            m2_next[e]  = f2[DW-1] ? DW'(-f2) : DW'(f2);
            md_next[e]  = dv[DW-1] ? DW'(-dv) : DW'(dv);
            neg1_next[e] = f1[DW-1] ^ f2[DW-1] ^ dv[DW-1];
            ctl1_next.tries[e] = tr;
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Advance payload: stage 1 setup, stage 2 multiply
    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_reg   <= m1_next;
            m2_reg   <= m2_next;
            md_reg   <= md_next;
            neg1_reg <= neg1_next;
            ctl1_reg <= ctl1_next;
            crd1_reg <= {by, bx, ay, ax};
            for (int e = 0; e < NumLanes; e++) begin
                prod_reg[e] <= PW'(m1_reg[e]) * PW'(m2_reg[e]);
            end
            md2_reg  <= md_reg;
            neg2_reg <= neg1_reg;
            ctl2_reg <= ctl1_reg;
            crd2_reg <= crd1_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign num       = prod_reg;
    assign den       = md2_reg;
    assign neg       = neg2_reg;
    assign ctl       = ctl2_reg;
    assign coords    = crd2_reg;

endmodule

[hdl/lsc_div.sv]
module lsc_div
    import lsc_pkg::*;
#(
    parameter int W = CoordWidth
) (
    input  logic            aclk,
    input  logic            adv,
    input  logic [2*W+1:0]  num,
    input  logic [W:0]      den,
    input  logic            neg,
    output logic [2*W+1:0]  quo,
    output logic            rnd,
    output logic            neg_o
);

    localparam int DW = W + 1;
    localparam int PW = 2 * DW;

    // One quotient bit per stage, restoring
    logic [DW-1:0] rem_reg [PW];
    logic [PW-1:0] nq_reg  [PW];
    logic [DW-1:0] den_reg [PW];
    logic          neg_reg [PW];
    logic [DW-1:0] rem_nx  [PW];
    logic [PW-1:0] nq_nx   [PW];

    for (genvar i = 0; i < PW; i++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [PW-1:0] nq_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign nq_in  = num;
            assign den_in = den;
        end else begin : g_next
            assign rem_in = rem_reg[i-1];
            assign nq_in  = nq_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        assign trial = {rem_in, nq_in[PW-1]};
        assign ge    = (trial >= {1'b0, den_in});
        assign diff  = trial - {1'b0, den_in};

        // Shift in the next dividend bit, subtract when it fits
        assign rem_nx[i] = ge ? diff[DW-1:0] : trial[DW-1:0];
        assign nq_nx[i]  = {nq_in[PW-2:0], ge};
    end

    // Advance all stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            den_reg[0] <= den;
            neg_reg[0] <= neg;
            for (int i = 0; i < PW; i++) begin
                rem_reg[i] <= rem_nx[i];
                nq_reg[i]  <= nq_nx[i];
            end
            for (int i = 1; i < PW; i++) begin
                den_reg[i] <= den_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    // Round half away from zero: remainder at least half the divisor
    assign quo   = nq_reg[PW-1];
    assign rnd   = ({rem_reg[PW-1], 1'b0} >= {1'b0, den_reg[PW-1]});
    assign neg_o = neg_reg[PW-1];

endmodule

[hdl/lsc_back.sv]
module lsc_back
    import lsc_pkg::*;
#(
    parameter int W = CoordWidth
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            adv,
    input  logic                            in_valid,
    input  logic [NumLanes-1:0][2*W+1:0]    quo,
    input  logic [NumLanes-1:0]             rnd,
    input  logic [NumLanes-1:0]             neg,
    input  lsc_ctl_t                        ctl,
    input  logic [4*W-1:0]                  coords,
    input  logic [W-1:0]                    win_l,
    input  logic [W-1:0]                    win_r,
    input  logic [W-1:0]                    win_b,
    input  logic [W-1:0]                    win_t,
    output logic                            out_valid,
    output logic                            visible,
    output logic [W-1:0]                    r1x,
    output logic [W-1:0]                    r1y,
    output logic [W-1:0]                    r2x,
    output logic [W-1:0]                    r2y
);

    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int VW = PW + 3;

    logic                            sv_valid_reg;
    logic [NumLanes-1:0][VW-1:0]     v_reg, v_next;
    lsc_ctl_t                        ctlv_reg;
    logic [4*W-1:0]                  crdv_reg;

    logic            o_valid_reg;
    logic            vis_reg, vis_next;
    logic [W-1:0]    r1x_reg, r1x_next, r1y_reg, r1y_next;
    logic [W-1:0]    r2x_reg, r2x_next, r2y_reg, r2y_next;

    // Apply rounding and sign, add the offset to the endpoint
    always_comb begin
        logic [W-1:0]   base;
        logic [PW:0]    qr;
        logic [VW-1:0]  ofs;
        for (int e = 0; e < NumLanes; e++) begin
            if (e[1]) begin
                base = (e >= 4) ? coords[2*W +: W] : coords[0 +: W];
            end else begin
                base = (e >= 4) ? coords[3*W +: W] : coords[W +: W];
            end
            qr  = {1'b0, quo[e]} + (PW+1)'(rnd[e]);
            ofs = neg[e] ? (VW'(0) - {2'b00, qr}) : {2'b00, qr};
            v_next[e] = {{(VW-W){base[W-1]}}, base} + ofs;
        end
    end

    // Test lanes against the window, pick the first edge per endpoint
    always_comb begin
        logic signed [VW-1:0] sl, sr, sb, st, lo, hi, v;
        logic [1:0]           ok_end;
        logic [W-1:0]         cx [2];
        logic [W-1:0]         cy [2];
        logic [3:0]           c1, c2;
        sl = VW'(signed'(win_l));
        sr = VW'(signed'(win_r));
        sb = VW'(signed'(win_b));
        st = VW'(signed'(win_t));
        ok_end = 2'b00;
        for (int p = 0; p < 2; p++) begin
            cx[p] = '0;
            cy[p] = '0;
            for (int k = 3; k >= 0; k--) begin
                v  = signed'(v_reg[p*4+k]);
                lo = (k >= 2) ? sl : sb;
                hi = (k >= 2) ? sr : st;
                if (ctlv_reg.tries[p*4+k] && (v >= lo) && (v <= hi)) begin
                    ok_end[p] = 1'b1;
                    case (lsc_edge_t'(k[1:0]))
                        EDGE_LEFT:   begin cx[p] = win_l;      cy[p] = v[W-1:0]; end
                        EDGE_RIGHT:  begin cx[p] = win_r;      cy[p] = v[W-1:0]; end
                        EDGE_TOP:    begin cx[p] = v[W-1:0];   cy[p] = win_t;    end
                        EDGE_BOTTOM: begin cx[p] = v[W-1:0];   cy[p] = win_b;    end
                        default:     begin cx[p] = '0;         cy[p] = '0;       end
                    endcase
                end
            end
        end
        c1 = ctlv_reg.c1;
        c2 = ctlv_reg.c2;
        r1x_next = crdv_reg[0 +: W];
        r1y_next = crdv_reg[W +: W];
        r2x_next = crdv_reg[2*W +: W];
        r2y_next = crdv_reg[3*W +: W];
        vis_next = 1'b1;
        if ((c1 | c2) != 4'd0) begin
            if ((c1 & c2) != 4'd0) begin
                vis_next = 1'b0;
            end else if (c1 == 4'd0) begin
                vis_next = ok_end[1];
                r2x_next = cx[1];
                r2y_next = cy[1];
            end else if (c2 == 4'd0) begin
                vis_next = ok_end[0];
                r1x_next = crdv_reg[2*W +: W];
                r1y_next = crdv_reg[3*W +: W];
                r2x_next = cx[0];
                r2y_next = cy[0];
            end else begin
                vis_next = ok_end[0] && ok_end[1];
                r1x_next = cx[0];
                r1y_next = cy[0];
                r2x_next = cx[1];
                r2y_next = cy[1];
            end
        end
        // Zero the endpoints of an invisible segment
        if (!vis_next) begin
            r1x_next = '0;
            r1y_next = '0;
            r2x_next = '0;
            r2y_next = '0;
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else if (adv) begin
            sv_valid_reg <= in_valid;
            o_valid_reg  <= sv_valid_reg;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            v_reg    <= v_next;
            ctlv_reg <= ctl;
            crdv_reg <= coords;
            vis_reg  <= vis_next;
            r1x_reg  <= r1x_next;
            r1y_reg  <= r1y_next;
            r2x_reg  <= r2x_next;
            r2y_reg  <= r2y_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign visible   = vis_reg;
    assign r1x       = r1x_reg;
    assign r1y       = r1y_reg;
    assign r2x       = r2x_reg;
    assign r2y       = r2y_reg;

endmodule

[hdl/line_segment_rect_clip_core.sv]
// Channel   Direction  Contents
// s_        in         segment item: ax, ay, bx, by
// m_        out        clip item: visible in tuser; r1x, r1y, r2x, r2y in tdata
// cfg_      in         window register write: index, data
//
// The restoring dividers produce one quotient bit per stage, in
// 2*COORD_WIDTH+2 stages.
// One segment per cycle is taken while the output side keeps up.
// All stages advance together; a stall on m_tready holds every stage.
// Reset clears valid bits and loads the default window (0..255 square).
// Window writes are taken every cycle; the window is read at entry and
// again near the output, so write it only while no item is in flight.
module line_segment_rect_clip_core
    import lsc_pkg::*;
#(
    parameter int COORD_WIDTH = CoordWidth
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,  // ax, ay, bx, by
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_tdata,  // r1x, r1y, r2x, r2y
    output logic [0:0]                    m_tuser,  // visible
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int PW  = 2 * DW;
    localparam int TDW = ((4*W+7)/8)*8;

    logic         adv;
    logic [W-1:0] x_left_reg, x_right_reg, y_bottom_reg, y_top_reg;

    logic                         f_valid;
    logic [NumLanes-1:0][PW-1:0]  f_num;
    logic [NumLanes-1:0][DW-1:0]  f_den;
    logic [NumLanes-1:0]          f_neg;
    lsc_ctl_t                     f_ctl;
    logic [4*W-1:0]               f_crd;

    logic [NumLanes-1:0][PW-1:0]  d_quo;
    logic [NumLanes-1:0]          d_rnd;
    logic [NumLanes-1:0]          d_neg;

    logic           dv_reg  [PW];
    lsc_ctl_t       dctl_reg[PW];
    logic [4*W-1:0] dcrd_reg[PW];

    logic         o_vis;
    logic [W-1:0] o_r1x, o_r1y, o_r2x, o_r2y;

    // Whole pipeline moves when the output register is free or drains
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // Window registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_left_reg   <= '0;
            x_right_reg  <= W'(255);
            y_bottom_reg <= '0;
            y_top_reg    <= W'(255);
        end else if (cfg_valid) begin
            case (lsc_cfg_idx_t'(cfg_index))
                CFG_X_LEFT:   x_left_reg   <= cfg_data;
                CFG_X_RIGHT:  x_right_reg  <= cfg_data;
                CFG_Y_BOTTOM: y_bottom_reg <= cfg_data;
                CFG_Y_TOP:    y_top_reg    <= cfg_data;
                default:      x_left_reg   <= x_left_reg;
            endcase
        end
    end

    lsc_front #(.W(W)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .ax        (s_tdata[0 +: W]),
        .ay        (s_tdata[W +: W]),
        .bx        (s_tdata[2*W +: W]),
        .by        (s_tdata[3*W +: W]),
        .win_l     (x_left_reg),
        .win_r     (x_right_reg),
        .win_b     (y_bottom_reg),
        .win_t     (y_top_reg),
        .out_valid (f_valid),
        .num       (f_num),
        .den       (f_den),
        .neg       (f_neg),
        .ctl       (f_ctl),
        .coords    (f_crd)
    );

    for (genvar e = 0; e < NumLanes; e++) begin : g_lane
        lsc_div #(.W(W)) u_div (
            .aclk  (aclk),
            .adv   (adv),
            .num   (f_num[e]),
            .den   (f_den[e]),
            .neg   (f_neg[e]),
            .quo   (d_quo[e]),
            .rnd   (d_rnd[e]),
            .neg_o (d_neg[e])
        );
    end

    // Carry valid, control and coordinates alongside the dividers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PW; i++) begin
                dv_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            dv_reg[0] <= f_valid;
            for (int i = 1; i < PW; i++) begin
                dv_reg[i] <= dv_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dctl_reg[0] <= f_ctl;
            dcrd_reg[0] <= f_crd;
            for (int i = 1; i < PW; i++) begin
                dctl_reg[i] <= dctl_reg[i-1];
                dcrd_reg[i] <= dcrd_reg[i-1];
            end
        end
    end

    lsc_back #(.W(W)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (dv_reg[PW-1]),
        .quo       (d_quo),
        .rnd       (d_rnd),
        .neg       (d_neg),
        .ctl       (dctl_reg[PW-1]),
        .coords    (dcrd_reg[PW-1]),
        .win_l     (x_left_reg),
        .win_r     (x_right_reg),
        .win_b     (y_bottom_reg),
        .win_t     (y_top_reg),
        .out_valid (m_tvalid),
        .visible   (o_vis),
        .r1x       (o_r1x),
        .r1y       (o_r1y),
        .r2x       (o_r2x),
        .r2y       (o_r2y)
    );

    assign m_tuser = o_vis;
    assign m_tdata = TDW'({o_r2y, o_r2x, o_r1y, o_r1x});

`ifndef SYNTHESIS
    // An invisible segment carries zero endpoints
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("invisible item with nonzero endpoints");

    // A visible first endpoint lies in the window
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            ($signed(o_r1x) >= $signed(x_left_reg)) &&
            ($signed(o_r1x) <= $signed(x_right_reg)) &&
            ($signed(o_r1y) >= $signed(y_bottom_reg)) &&
            ($signed(o_r1y) <= $signed(y_top_reg)))
        else $error("first endpoint outside window");

    // A visible second endpoint lies in the window
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            ($signed(o_r2x) >= $signed(x_left_reg)) &&
            ($signed(o_r2x) <= $signed(x_right_reg)) &&
            ($signed(o_r2y) >= $signed(y_bottom_reg)) &&
            ($signed(o_r2y) <= $signed(y_top_reg)))
        else $error("second endpoint outside window");
`endif

endmodule
